>>> design/polyline_length_two_channel_defines.svh
// assertion macros shared by the polyline length design files
`ifndef POLYLINE_LENGTH_TWO_CHANNEL_DEFINES_SVH
`define POLYLINE_LENGTH_TWO_CHANNEL_DEFINES_SVH

`ifndef SYNTHESIS
// clocked assertion, switched off while reset is asserted (reset is active low)
`define PL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// clocked assertion that also holds through reset
`define PL_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error(msg);
`else
`define PL_ASSERT(lbl, clk, rst_n, prop, msg)
`define PL_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

>>> design/polylen_pkg.sv
// shared constants for the two channel polyline length block
`timescale 1ns / 1ps
`default_nettype none

package polylen_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF    = 8;
    localparam int SAMPLE_WIDTH_DEF = 8;

    // fixed field and state widths
    localparam int STEP_W  = 16;
    localparam int RUN_W   = 24;
    localparam int TOTAL_W = 16;

    // reset value of the step length register
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd336;

endpackage

`default_nettype wire

>>> design/polylen_if.sv
// input and output channel interfaces of the polyline length block
`timescale 1ns / 1ps
`default_nettype none

// input channel: one pair of samples plus run flags per item
interface polylen_in_if
    import polylen_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_left;
    logic [SAMPLE_WIDTH-1:0] sample_right;
    logic                    first_sample;
    logic                    last_sample;
    logic                    clear_totals;

    modport source (
        output valid, sample_left, sample_right, first_sample, last_sample, clear_totals,
        input  ready
    );

    modport sink (
        input  valid, sample_left, sample_right, first_sample, last_sample, clear_totals,
        output ready
    );
endinterface

// output channel: the two running totals per item
interface polylen_out_if
    import polylen_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_left;
    logic [TOTAL_W-1:0] total_right;

    modport source (
        output valid, total_left, total_right,
        input  ready
    );

    modport sink (
        input  valid, total_left, total_right,
        output ready
    );
endinterface

`default_nettype wire

>>> design/polyline_length_two_channel.sv
// top level: two channel polyline length with saturating running totals
//
//  channel   dir  payload                                            handshake
//  i_in      in   sample_left, sample_right, first/last, clear      valid/ready
//  o_out     out  total_left, total_right                            valid/ready
//  i_cfg     in   step_length (16 bits)                              write enable
//
// a segment item passes through the square, start and root states, paced by the
// bit serial square root that retires one root bit per cycle, one unit per side
// a first sample item stays in the idle state unless also last; a last sample adds the emit step
// reset is synchronous active low and restores the step length to 336
// the output register holds a result while the next item is taken in; a last
// sample item waits in the emit step only while that register is still full
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_length_two_channel_defines.svh"

module polyline_length_two_channel
    import polylen_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [STEP_W-1:0] i_cfg_wr_data,
    polylen_in_if.sink             i_in,
    polylen_out_if.source          o_out
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int FB      = FRAC_BITS;
    localparam int D2_W    = 2 * (SW + FB);
    localparam int S2_W    = 2 * STEP_W;
    localparam int RAD_W   = (D2_W > S2_W) ? D2_W : S2_W;
    localparam int SUM_W   = RAD_W + 1;
    localparam int RW_EVEN = SUM_W + (SUM_W % 2);
    localparam int RW      = (RW_EVEN > 64) ? 64 : RW_EVEN;
    localparam int RH      = RW / 2;
    localparam int AW      = ((RH > RUN_W) ? RH : RUN_W) + 1;
    localparam int RND_W   = RUN_W + 1;
    localparam int TS_W    = (((RND_W - FB) > TOTAL_W) ? (RND_W - FB) : TOTAL_W) + 1;

    localparam logic [AW-1:0]    RUN_MAX   = AW'((64'd1 << RUN_W) - 64'd1);
    localparam logic [RND_W-1:0] HALF      = RND_W'(64'd1 << (FB - 1));
    localparam logic [TS_W-1:0]  TOTAL_MAX = TS_W'((64'd1 << TOTAL_W) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_START,
        ST_ROOT,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [STEP_W-1:0]  r_step;
    logic [SW-1:0]      r_prev_l;
    logic [SW-1:0]      r_prev_r;
    logic [SW-1:0]      r_dy_l;
    logic [SW-1:0]      r_dy_r;
    logic [2*SW-1:0]    r_dy2_l;
    logic [2*SW-1:0]    r_dy2_r;
    logic [S2_W-1:0]    r_s2;
    logic [RUN_W-1:0]   r_run_l;
    logic [RUN_W-1:0]   r_run_r;
    logic [TOTAL_W-1:0] r_grand_l;
    logic [TOTAL_W-1:0] r_grand_r;
    logic               r_last;
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_l;
    logic [TOTAL_W-1:0] r_out_r;

    logic               w_accept;
    logic               w_start;
    logic               w_done_l;
    logic               w_done_r;
    logic [RH-1:0]      w_root_l;
    logic [RH-1:0]      w_root_r;
    logic [SW-1:0]      n_dy_l;
    logic [SW-1:0]      n_dy_r;
    logic [RW_EVEN-1:0] n_sum_l;
    logic [RW_EVEN-1:0] n_sum_r;
    logic [RW-1:0]      n_rad_l;
    logic [RW-1:0]      n_rad_r;
    logic [AW-1:0]      n_acc_l;
    logic [AW-1:0]      n_acc_r;
    logic [RUN_W-1:0]   n_run_l;
    logic [RUN_W-1:0]   n_run_r;
    logic [RND_W-1:0]   n_rnd_l;
    logic [RND_W-1:0]   n_rnd_r;
    logic [TS_W-1:0]    n_tot_l;
    logic [TS_W-1:0]    n_tot_r;
    logic [TOTAL_W-1:0] n_grand_l;
    logic [TOTAL_W-1:0] n_grand_r;

    // handshake
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_start     = (r_state == ST_START);
    assign o_out.valid       = r_out_valid;
    assign o_out.total_left  = r_out_l;
    assign o_out.total_right = r_out_r;

    // absolute sample differences
    always_comb begin
        n_dy_l = (i_in.sample_left >= r_prev_l) ? (i_in.sample_left - r_prev_l)
                                                : (r_prev_l - i_in.sample_left);
        n_dy_r = (i_in.sample_right >= r_prev_r) ? (i_in.sample_right - r_prev_r)
                                                 : (r_prev_r - i_in.sample_right);
    end

    // radicand (dy << frac)^2 + step^2, saturated to the root unit width
    always_comb begin
        n_sum_l = ({{(RW_EVEN - 2*SW){1'b0}}, r_dy2_l} << (2*FB))
                + {{(RW_EVEN - S2_W){1'b0}}, r_s2};
        n_sum_r = ({{(RW_EVEN - 2*SW){1'b0}}, r_dy2_r} << (2*FB))
                + {{(RW_EVEN - S2_W){1'b0}}, r_s2};
        n_rad_l = ((n_sum_l >> RW) != '0) ? {RW{1'b1}} : n_sum_l[RW-1:0];
        n_rad_r = ((n_sum_r >> RW) != '0) ? {RW{1'b1}} : n_sum_r[RW-1:0];
    end

    // saturating run sums
    always_comb begin
        n_acc_l = AW'(r_run_l) + AW'(w_root_l);
        n_acc_r = AW'(r_run_r) + AW'(w_root_r);
        n_run_l = (n_acc_l > RUN_MAX) ? RUN_W'(RUN_MAX) : n_acc_l[RUN_W-1:0];
        n_run_r = (n_acc_r > RUN_MAX) ? RUN_W'(RUN_MAX) : n_acc_r[RUN_W-1:0];
    end

    // round half up and add into the saturating totals
    always_comb begin
        n_rnd_l   = ({1'b0, r_run_l} + HALF) >> FB;
        n_rnd_r   = ({1'b0, r_run_r} + HALF) >> FB;
        n_tot_l   = TS_W'(n_rnd_l) + TS_W'(r_grand_l);
        n_tot_r   = TS_W'(n_rnd_r) + TS_W'(r_grand_r);
        n_grand_l = (n_tot_l > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : n_tot_l[TOTAL_W-1:0];
        n_grand_r = (n_tot_r > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : n_tot_r[TOTAL_W-1:0];
    end

    // one square root unit per side
    polylen_sqrt #(
        .RAD_W (RW)
    ) u_sqrt_l (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_radicand (n_rad_l),
        .o_done     (w_done_l),
        .o_root     (w_root_l)
    );

    polylen_sqrt #(
        .RAD_W (RW)
    ) u_sqrt_r (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_radicand (n_rad_r),
        .o_done     (w_done_r),
        .o_root     (w_root_r)
    );

    // sequencer, run state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_RESET;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_run_l     <= '0;
            r_run_r     <= '0;
            r_grand_l   <= '0;
            r_grand_r   <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_step <= i_cfg_wr_data;
            end
            // the emit step reloads the output register itself
            if (r_out_valid && o_out.ready && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_prev_l <= i_in.sample_left;
                        r_prev_r <= i_in.sample_right;
                        r_dy_l   <= n_dy_l;
                        r_dy_r   <= n_dy_r;
                        r_last   <= i_in.last_sample;
                        if (i_in.first_sample) begin
                            r_run_l <= '0;
                            r_run_r <= '0;
                            if (i_in.clear_totals) begin
                                r_grand_l <= '0;
                                r_grand_r <= '0;
                            end
                            if (i_in.last_sample) begin
                                r_state <= ST_EMIT;
                            end
                        end else begin
                            r_state <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE: begin
                    r_dy2_l <= {{SW{1'b0}}, r_dy_l} * {{SW{1'b0}}, r_dy_l};
                    r_dy2_r <= {{SW{1'b0}}, r_dy_r} * {{SW{1'b0}}, r_dy_r};
                    r_s2    <= {{STEP_W{1'b0}}, r_step} * {{STEP_W{1'b0}}, r_step};
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (w_done_l) begin
                        r_run_l <= n_run_l;
                        r_run_r <= n_run_r;
                        r_state <= r_last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_grand_l   <= n_grand_l;
                        r_grand_r   <= n_grand_r;
                        r_out_l     <= n_grand_l;
                        r_out_r     <= n_grand_r;
                        r_out_valid <= 1'b1;
                        r_run_l     <= '0;
                        r_run_r     <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `PL_ASSERT_NR(a_roots_together, i_clk, w_done_l === w_done_r, "root units out of step")
    `PL_ASSERT(a_done_in_root, i_clk, i_rst_n, w_done_l |-> (r_state == ST_ROOT), "root done outside wait")
    `PL_ASSERT(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == ST_EMIT), "result not from emit")

endmodule

`default_nettype wire

>>> design/polylen_sqrt.sv
// bit serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
`default_nettype none
`include "polyline_length_two_channel_defines.svh"

module polylen_sqrt #(
    parameter int RAD_W = 34
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [RAD_W-1:0]   i_radicand,
    output logic                    o_done,
    output logic [RAD_W/2-1:0]      o_root
);

    localparam int RH    = RAD_W / 2;
    localparam int REM_W = RH + 2;
    localparam int CNT_W = $clog2(RH + 1);

    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [RH-1:0]    r_root;
    logic [CNT_W-1:0] r_count;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] n_rem_sh;
    logic [REM_W-1:0] n_trial;
    logic             n_ge;

    // one root bit per step: bring down two radicand bits, try subtract
    always_comb begin
        n_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        n_trial  = {r_root, 2'b01};
        n_ge     = (n_rem_sh >= n_trial);
    end

    // iteration control and datapath shift registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            // done pulses the cycle after the last step
            r_done <= r_busy && !i_start && (r_count == CNT_W'(1));
            if (i_start) begin
                r_rad   <= i_radicand;
                r_rem   <= '0;
                r_root  <= '0;
                r_count <= CNT_W'(RH);
                r_busy  <= 1'b1;
            end else if (r_busy) begin
                r_rad   <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem   <= n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
                r_root  <= {r_root[RH-2:0], n_ge};
                r_count <= r_count - CNT_W'(1);
                if (r_count == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

    `PL_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_start |-> !r_busy, "sqrt started while busy")
    `PL_ASSERT(a_done_after_busy, i_clk, i_rst_n, r_done |-> $past(r_busy), "sqrt done without run")
    `PL_ASSERT(a_done_pulse, i_clk, i_rst_n, r_done |=> !r_done, "sqrt done longer than a cycle")

endmodule

`default_nettype wire

>>> verif/polyline_length_two_channel_test.sv
// testbench for the two channel polyline length block: directed and random runs checked against a predictor
`timescale 1ns / 1ps

import polylen_pkg::*;

// one pair of running totals as the block emits them
typedef struct packed {
    logic [TOTAL_W-1:0] left;
    logic [TOTAL_W-1:0] right;
} t_totals;

// tracks the path length state of both sides and the totals still to come
class path_total_tracker;
    logic [STEP_W-1:0]           step_len   = STEP_RESET;
    logic [SAMPLE_WIDTH_DEF-1:0] prev_left  = '0;
    logic [SAMPLE_WIDTH_DEF-1:0] prev_right = '0;
    logic [RUN_W-1:0]            run_left   = '0;
    logic [RUN_W-1:0]            run_right  = '0;
    logic [TOTAL_W-1:0]          grand_left  = '0;
    logic [TOTAL_W-1:0]          grand_right = '0;
    t_totals                     pending_totals[$];
    int                          failures = 0;
    int                          checked = 0;
    int                          runs_started = 0;

    // largest root whose square fits the radicand, one bit at a time from the top
    function bit [63:0] floor_root(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    // straight segment length between two samples, FRAC_BITS fraction bits
    function bit [63:0] segment_len(logic [SAMPLE_WIDTH_DEF-1:0] prv,
                                    logic [SAMPLE_WIDTH_DEF-1:0] cur);
        bit [63:0] a;
        bit [63:0] b;
        bit [63:0] rise;
        bit [63:0] dx;
        a = 64'(prv);
        b = 64'(cur);
        rise = (a >= b) ? (a - b) : (b - a);
        rise = rise << FRAC_BITS_DEF;
        dx = 64'(step_len);
        return floor_root(rise * rise + dx * dx);
    endfunction

    // run accumulator, saturates at all ones
    function logic [RUN_W-1:0] run_add(logic [RUN_W-1:0] acc, bit [63:0] seg);
        bit [63:0] sum;
        bit [63:0] top;
        top = (64'd1 << RUN_W) - 64'd1;
        sum = 64'(acc) + seg;
        if (sum > top)
            sum = top;
        return sum[RUN_W-1:0];
    endfunction

    // round the run half up and add it to a saturating total
    function logic [TOTAL_W-1:0] total_add(logic [TOTAL_W-1:0] total, logic [RUN_W-1:0] run);
        bit [63:0] sum;
        sum = 64'(total) + ((64'(run) + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF);
        if (sum > 64'hFFFF)
            sum = 64'hFFFF;
        return sum[TOTAL_W-1:0];
    endfunction

    // an item went into the block: advance the state, queue totals on a last sample
    function void note_sample(logic [SAMPLE_WIDTH_DEF-1:0] left,
                              logic [SAMPLE_WIDTH_DEF-1:0] right,
                              logic first, logic last, logic clear);
        t_totals t;
        if (first) begin
            runs_started++;
            run_left = '0;
            run_right = '0;
            if (clear) begin
                grand_left = '0;
                grand_right = '0;
            end
        end else begin
            run_left = run_add(run_left, segment_len(prev_left, left));
            run_right = run_add(run_right, segment_len(prev_right, right));
        end
        prev_left = left;
        prev_right = right;
        if (last) begin
            grand_left = total_add(grand_left, run_left);
            grand_right = total_add(grand_right, run_right);
            run_left = '0;
            run_right = '0;
            t.left = grand_left;
            t.right = grand_right;
            pending_totals.push_back(t);
        end
    endfunction

    function void flag(string what);
        failures++;
        if (failures <= 10)
            $display("mismatch: %s", what);
    endfunction

    // a result came out: compare it with the oldest queued totals
    function void check_totals(logic [TOTAL_W-1:0] left, logic [TOTAL_W-1:0] right);
        t_totals want;
        checked++;
        if (pending_totals.size() == 0) begin
            flag($sformatf("unexpected totals left %0d right %0d", left, right));
            return;
        end
        want = pending_totals.pop_front();
        if (left !== want.left)
            flag($sformatf("total_left expected %0d got %0d", want.left, left));
        if (right !== want.right)
            flag($sformatf("total_right expected %0d got %0d", want.right, right));
    endfunction
endclass

module polyline_length_two_channel_test;

    // cycles an item without a result may still be busy, plus slack
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES    = 60;
    localparam int PHASE_ITEMS   = 160;
    localparam int SAT_SEGMENTS  = 200;

    typedef enum int { STYLE_NOISE, STYLE_WALK, STYLE_EXTREME } t_level_style;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              cfg_wr_en;
    logic [STEP_W-1:0] cfg_wr_data;

    bit calm = 1'b0;
    int samples_sent = 0;
    int steps_written = 0;
    logic [SAMPLE_WIDTH_DEF-1:0] level_left = '0;
    logic [SAMPLE_WIDTH_DEF-1:0] level_right = '0;

    path_total_tracker tracker = new;

    polylen_in_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH_DEF)) in_ch ();
    polylen_out_if out_ch ();

    polyline_length_two_channel #(
        .FRAC_BITS    (FRAC_BITS_DEF),
        .SAMPLE_WIDTH (SAMPLE_WIDTH_DEF)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // next sample level for one side
    function automatic logic [SAMPLE_WIDTH_DEF-1:0] next_level(
            logic [SAMPLE_WIDTH_DEF-1:0] from, t_level_style style);
        int v;
        int jitter;
        case (style)
            STYLE_WALK: begin
                jitter = $urandom_range(0, 20);
                v = int'(from) + jitter - 10;
                if (v < 0)
                    v = 0;
                if (v > 255)
                    v = 255;
                return 8'(v);
            end
            STYLE_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // output side: random back pressure, none while calm
    initial begin : out_stall
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (calm) begin
                out_ch.ready = 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                out_ch.ready = 1'b0;
                hold--;
            end else if ($urandom_range(0, 99) < 25) begin
                out_ch.ready = 1'b0;
                hold = pick_gap();
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // both handshakes seen at the rising edge: results checked, items noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                tracker.check_totals(out_ch.total_left, out_ch.total_right);
            if (in_ch.valid && in_ch.ready)
                tracker.note_sample(in_ch.sample_left, in_ch.sample_right,
                                    in_ch.first_sample, in_ch.last_sample,
                                    in_ch.clear_totals);
        end
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_sample(logic [SAMPLE_WIDTH_DEF-1:0] left,
                               logic [SAMPLE_WIDTH_DEF-1:0] right,
                               logic first, logic last, logic clear);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.sample_left = left;
        in_ch.sample_right = right;
        in_ch.first_sample = first;
        in_ch.last_sample = last;
        in_ch.clear_totals = clear;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        @(negedge i_clk);
        samples_sent++;
    endtask

    // hold off the sender until every queued total is out and the block is quiet
    task automatic wait_for_totals();
        in_ch.valid = 1'b0;
        while (tracker.pending_totals.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_step(logic [STEP_W-1:0] value);
        wait_for_totals();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        tracker.step_len = value;
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
        steps_written++;
    endtask

    // one well formed run: first, some middle samples, last; or a lone first and last sample
    task automatic send_run(int segs, logic clear);
        t_level_style style;
        int r;
        r = $urandom_range(0, 9);
        style = (r < 4) ? STYLE_NOISE : (r < 8) ? STYLE_WALK : STYLE_EXTREME;
        level_left = next_level(level_left, style);
        level_right = next_level(level_right, style);
        if (segs == 0 && $urandom_range(0, 1) != 0) begin
            send_sample(level_left, level_right, 1'b1, 1'b1, clear);
            return;
        end
        send_sample(level_left, level_right, 1'b1, 1'b0, clear);
        repeat (segs) begin
            level_left = next_level(level_left, style);
            level_right = next_level(level_right, style);
            send_sample(level_left, level_right, 1'b0, 1'b0, 1'b0);
        end
        level_left = next_level(level_left, style);
        level_right = next_level(level_right, style);
        send_sample(level_left, level_right, 1'b0, 1'b1, 1'b0);
    endtask

    // step length for each random phase, extremes included
    function automatic logic [STEP_W-1:0] phase_step(int phase);
        case (phase)
            0: return STEP_RESET;
            1: return 16'($urandom_range(1, 65535));
            2: return 16'hFFFF;
            3: return 16'd1;
            4: return 16'($urandom_range(100, 600));
            5: return 16'd0;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    initial begin : main_seq
        int phase;
        int phase_start;
        bit paused;
        i_rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sample_left = '0;
        in_ch.sample_right = '0;
        in_ch.first_sample = 1'b0;
        in_ch.last_sample = 1'b0;
        in_ch.clear_totals = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: a segment against the reset previous, clear without first ignored
        send_sample(8'd255, 8'd128, 1'b0, 1'b0, 1'b1);
        send_sample(8'd3, 8'd4, 1'b0, 1'b1, 1'b0);
        // full swing run from a cleared start
        send_sample(8'd0, 8'd0, 1'b1, 1'b0, 1'b1);
        send_sample(8'd255, 8'd0, 1'b0, 1'b0, 1'b0);
        send_sample(8'd0, 8'd255, 1'b0, 1'b0, 1'b0);
        send_sample(8'd255, 8'd255, 1'b0, 1'b1, 1'b0);
        // last twice in a row: the second counts only its own segment
        send_sample(8'd200, 8'd10, 1'b0, 1'b1, 1'b0);
        send_sample(8'd200, 8'd10, 1'b0, 1'b1, 1'b0);
        // single sample runs, unchanged and then cleared
        send_sample(8'd5, 8'd5, 1'b1, 1'b1, 1'b0);
        send_sample(8'd9, 8'd9, 1'b1, 1'b1, 1'b1);
        // zero step: each segment is just the height difference
        write_step(16'd0);
        send_sample(8'd10, 8'd250, 1'b1, 1'b0, 1'b0);
        send_sample(8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_sample(8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        send_sample(8'd128, 8'd7, 1'b0, 1'b1, 1'b0);
        // widest step
        write_step(16'hFFFF);
        send_sample(8'd0, 8'd255, 1'b1, 1'b0, 1'b1);
        send_sample(8'd255, 8'd0, 1'b0, 1'b0, 1'b0);
        send_sample(8'd0, 8'd255, 1'b0, 1'b1, 1'b0);
        // narrowest nonzero step
        write_step(16'd1);
        send_sample(8'd1, 8'd2, 1'b1, 1'b0, 1'b0);
        send_sample(8'd254, 8'd253, 1'b0, 1'b1, 1'b0);

        // random phases, one step setting each, a drain halfway through
        for (phase = 0; phase < 8; phase++) begin
            write_step(phase_step(phase));
            calm = (phase == 2 || phase == 6);
            phase_start = samples_sent;
            paused = 1'b0;
            while (samples_sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 15)
                    send_sample(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
                else
                    send_run($urandom_range(0, 12), 1'($urandom_range(0, 3) == 0));
                if (!paused && samples_sent - phase_start >= PHASE_ITEMS / 2) begin
                    wait_for_totals();
                    paused = 1'b1;
                end
            end
        end

        // long steep run at the widest step: run sums and totals both saturate
        calm = 1'b0;
        write_step(16'hFFFF);
        send_sample(8'd0, 8'd255, 1'b1, 1'b0, 1'b1);
        for (int n = 0; n < SAT_SEGMENTS; n++)
            send_sample((n % 2 == 0) ? 8'd255 : 8'd0, 8'($urandom_range(0, 255)),
                        1'b0, 1'b0, 1'b0);
        send_sample(8'd0, 8'd255, 1'b0, 1'b1, 1'b0);
        // further runs without clear keep the totals pinned
        repeat (4) send_run($urandom_range(1, 6), 1'b0);

        wait_for_totals();
        repeat (END_CYCLES) @(negedge i_clk);
        $display("summary: %0d samples in %0d runs, %0d totals compared, %0d step writes",
                 samples_sent, tracker.runs_started, tracker.checked, steps_written);
        $display("summary: zero, unit, default and full steps; run and total saturation");
        if (tracker.failures == 0 && tracker.pending_totals.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("mismatches: %0d, totals never seen: %0d",
                     tracker.failures, tracker.pending_totals.size());
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop if the block hangs
    initial begin : watchdog
        #10_000_000;
        $display("timeout with %0d totals outstanding", tracker.pending_totals.size());
        $display("tb: failure");
        $finish;
    end

endmodule
